>>> rtl/core/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// shared widths and the command and status bundles between controller and
// datapath of the spanning tree engine
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int NUM_VTX   = 16;
  localparam int VTX_W     = 4;
  localparam int NUM_CELLS = NUM_VTX * NUM_VTX;
  localparam int CELL_W    = 2 * VTX_W;
  localparam int WT_W      = 16;
  localparam int TOT_W     = 20;
  localparam int CNT_W     = 5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_RUN   = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic run_load;
    logic init;
    logic round_start;
    logic scan_step;
    logic link;
    logic emit_disc;
    logic emit_single;
  } mst_cmd_t;

  typedef struct packed {
    logic n_is_one;
    logic scan_last;
    logic found;
    logic round_last;
  } mst_sts_t;

endpackage

>>> rtl/core/minimum_spanning_tree_engine.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_engine
// loads a 16 x 16 adjacency weight matrix and builds a minimum spanning tree
// by repeated minimum edge scans over a component label table
// ----------------------------------------------------------------------------
//  channel   signals                                 transfer
//  command   start, busy, mode_i, row/col/weight     start && !busy
//  result    out_strobe_o, edge_number_o .. last_o   out_strobe_o, one cycle
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i    cfg_valid_i && cfg_ready_o
//
//  back to back matrix writes are taken every cycle while the engine is idle
//  a run for n vertices has at most n-1 rounds, and each round
//  reads every active cell once through the single read port of the matrix
//  reset clears all cell present bits at once, no clearing pass is needed
//  results cannot be stalled, each strobe is a transfer
// ----------------------------------------------------------------------------
module minimum_spanning_tree_engine import mst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             mode_i,
  input  logic [VTX_W-1:0] row_vertex_i,
  input  logic [VTX_W-1:0] col_vertex_i,
  input  logic [WT_W-1:0]  edge_weight_i,
  input  logic             edge_present_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i,
  output logic             out_strobe_o,
  output logic [VTX_W-1:0] edge_number_o,
  output logic [VTX_W-1:0] from_vertex_o,
  output logic [VTX_W-1:0] to_vertex_o,
  output logic [WT_W-1:0]  edge_cost_o,
  output logic [TOT_W-1:0] running_total_o,
  output logic             edge_valid_o,
  output logic             disconnected_o,
  output logic             last_o
);

  mst_cmd_t cmd;
  mst_sts_t sts;

  // no config transfer while a command transfer is offered
  assign cfg_ready_o = !busy && !start;

  mst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  mst_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .row_i           (row_vertex_i),
    .col_i           (col_vertex_i),
    .wt_i            (edge_weight_i),
    .pres_i          (edge_present_i),
    .res_valid_o     (out_strobe_o),
    .edge_number_o   (edge_number_o),
    .from_vertex_o   (from_vertex_o),
    .to_vertex_o     (to_vertex_o),
    .edge_cost_o     (edge_cost_o),
    .running_total_o (running_total_o),
    .edge_valid_o    (edge_valid_o),
    .disconnected_o  (disconnected_o),
    .last_o          (last_o)
  );

  // results only come out of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(busy))
    else $error("result strobe without a run in progress");

  // the final result of a run leaves the engine idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && last_o) |-> !busy)
    else $error("engine still busy after final result");

  // intermediate results come while the run goes on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_o) |-> (busy && edge_valid_o && !disconnected_o))
    else $error("intermediate result malformed or run ended");

endmodule

>>> rtl/core/mst_ctrl.sv
// ----------------------------------------------------------------------------
// mst_ctrl
// sequencer for matrix writes and the round by round spanning tree scan
// ----------------------------------------------------------------------------
module mst_ctrl import mst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     mode_i,
  input  mst_sts_t sts_i,
  output mst_cmd_t cmd_o,
  output logic     busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_DRAIN,
    S_RESOLVE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (mode_i == MODE_RUN) begin
            cmd_o.run_load = 1'b1;
            state_d        = S_INIT;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_INIT: begin
        cmd_o.init        = 1'b1;
        cmd_o.round_start = 1'b1;
        if (sts_i.n_is_one) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (sts_i.found) begin
          cmd_o.link = 1'b1;
          if (sts_i.round_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.round_start = 1'b1;
            state_d           = S_SCAN;
          end
        end else begin
          cmd_o.emit_disc = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/core/mst_dp.sv
// ----------------------------------------------------------------------------
// mst_dp
// weight matrix, component labels, scan counters, minimum tracking and
// result register
// ----------------------------------------------------------------------------
module mst_dp import mst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mst_cmd_t         cmd_i,
  output mst_sts_t         sts_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  logic [VTX_W-1:0] row_i,
  input  logic [VTX_W-1:0] col_i,
  input  logic [WT_W-1:0]  wt_i,
  input  logic             pres_i,
  output logic             res_valid_o,
  output logic [VTX_W-1:0] edge_number_o,
  output logic [VTX_W-1:0] from_vertex_o,
  output logic [VTX_W-1:0] to_vertex_o,
  output logic [WT_W-1:0]  edge_cost_o,
  output logic [TOT_W-1:0] running_total_o,
  output logic             edge_valid_o,
  output logic             disconnected_o,
  output logic             last_o
);

  logic [WT_W-1:0]      mem_q [NUM_CELLS];
  logic [NUM_CELLS-1:0] pres_q;
  logic [CNT_W-1:0]     vcount_q;
  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     n_clamp;
  logic [VTX_W-1:0]     comp_q [NUM_VTX];

  logic [VTX_W-1:0]     row_q, col_q;
  logic                 col_last, row_last;
  logic [CELL_W-1:0]    issue_addr;

  logic                 rd_valid_q;
  logic                 rd_pres_q;
  logic [WT_W-1:0]      rd_wt_q;
  logic [VTX_W-1:0]     rd_row_q, rd_col_q;
  logic [NUM_VTX-1:0]   mask_q, mask_d;
  logic [VTX_W-1:0]     row_root_q, row_root;

  logic                 found_q;
  logic [WT_W-1:0]      best_q;
  logic [VTX_W-1:0]     bi_q, bj_q, ri_q;
  logic [VTX_W-1:0]     rj;
  logic                 take;

  logic [VTX_W-1:0]     round_q;
  logic [TOT_W-1:0]     total_q;
  logic [TOT_W-1:0]     total_next;

  logic                 res_valid_q;

  always_comb begin
    if (vcount_q == '0) begin
      n_clamp = CNT_W'(1);
    end else if (vcount_q > CNT_W'(NUM_VTX)) begin
      n_clamp = CNT_W'(NUM_VTX);
    end else begin
      n_clamp = vcount_q;
    end
  end

  assign col_last   = ({1'b0, col_q} == (n_q - CNT_W'(1)));
  assign row_last   = ({1'b0, row_q} == (n_q - CNT_W'(1)));
  assign issue_addr = {row_q, col_q};

  assign row_root = comp_q[row_q];
  always_comb begin
    for (int v = 0; v < NUM_VTX; v++) begin
      mask_d[v] = (comp_q[v] == row_root);
    end
  end

  assign take = rd_valid_q && rd_pres_q && !mask_q[rd_col_q] &&
                (!found_q || (rd_wt_q < best_q));

  assign rj         = comp_q[bj_q];
  assign total_next = total_q + TOT_W'(best_q);

  assign sts_o.n_is_one   = (n_q == CNT_W'(1));
  assign sts_o.scan_last  = col_last && row_last;
  assign sts_o.found      = found_q;
  assign sts_o.round_last = ((CNT_W'(round_q) + CNT_W'(2)) == n_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q      <= '0;
      vcount_q    <= CNT_W'(NUM_VTX);
      rd_valid_q  <= 1'b0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_data_i;
      end
      if (cmd_i.wr_en) begin
        pres_q[{row_i, col_i}] <= pres_i;
      end
      rd_valid_q <= cmd_i.scan_step;
      if (cmd_i.round_start) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      res_valid_q <= cmd_i.emit_single | cmd_i.link | cmd_i.emit_disc;
    end
  end

  // weight memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[{row_i, col_i}] <= wt_i;
    end
    if (cmd_i.scan_step) begin
      rd_wt_q   <= mem_q[issue_addr];
      rd_pres_q <= pres_q[issue_addr];
    end
  end

  // scan, labels and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.run_load) begin
      n_q <= n_clamp;
    end

    if (cmd_i.round_start) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.scan_step) begin
      rd_row_q <= row_q;
      rd_col_q <= col_q;
      if (col_q == '0) begin
        mask_q     <= mask_d;
        row_root_q <= row_root;
      end
      if (col_last) begin
        col_q <= '0;
        row_q <= row_q + VTX_W'(1);
      end else begin
        col_q <= col_q + VTX_W'(1);
      end
    end

    if (take) begin
      best_q <= rd_wt_q;
      bi_q   <= rd_row_q;
      bj_q   <= rd_col_q;
      ri_q   <= row_root_q;
    end

    if (cmd_i.init) begin
      for (int v = 0; v < NUM_VTX; v++) begin
        comp_q[v] <= VTX_W'(v);
      end
      round_q <= '0;
      total_q <= '0;
    end else if (cmd_i.link) begin
      for (int v = 0; v < NUM_VTX; v++) begin
        if (comp_q[v] == rj) begin
          comp_q[v] <= ri_q;
        end
      end
      round_q <= round_q + VTX_W'(1);
      total_q <= total_next;
    end

    if (cmd_i.emit_single) begin
      edge_number_o   <= '0;
      from_vertex_o   <= '0;
      to_vertex_o     <= '0;
      edge_cost_o     <= '0;
      running_total_o <= '0;
      edge_valid_o    <= 1'b0;
      disconnected_o  <= 1'b0;
      last_o          <= 1'b1;
    end else if (cmd_i.link) begin
      edge_number_o   <= round_q;
      from_vertex_o   <= bi_q;
      to_vertex_o     <= bj_q;
      edge_cost_o     <= best_q;
      running_total_o <= total_next;
      edge_valid_o    <= 1'b1;
      disconnected_o  <= 1'b0;
      last_o          <= sts_o.round_last;
    end else if (cmd_i.emit_disc) begin
      edge_number_o   <= round_q;
      from_vertex_o   <= '0;
      to_vertex_o     <= '0;
      edge_cost_o     <= '0;
      running_total_o <= total_q;
      edge_valid_o    <= 1'b0;
      disconnected_o  <= 1'b1;
      last_o          <= 1'b1;
    end
  end

  assign res_valid_o = res_valid_q;

endmodule
